// ===== design/kce_pkg.sv =====
// Shared types and constants of the k-combination enumerator.
`default_nettype none
package kce_pkg;

  localparam int unsigned CFG_W  = 6;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [CFG_W-1:0] RST_N_ITEMS  = 6'd32;
  localparam logic [CFG_W-1:0] RST_K_CHOOSE = 6'd1;

  typedef enum logic {
    REG_N_ITEMS  = 1'b0,
    REG_K_CHOOSE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic k_zero;
    logic bit_set;
    logic is_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/kce_cfg.sv =====
// APB register file holding the set size and subset size.
`default_nettype none
module kce_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kce_pkg::APB_AW-1:0]  paddr,
  input  wire logic [kce_pkg::APB_DW-1:0]  pwdata,
  output logic      [kce_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [kce_pkg::CFG_W-1:0]   n_items_o,
  output logic      [kce_pkg::CFG_W-1:0]   k_choose_o,
  output logic                             cfg_wr_o
);
  import kce_pkg::*;

  logic [CFG_W-1:0] n_items_q;
  logic [CFG_W-1:0] k_choose_q;
  reg_idx_e         reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_items_q  <= RST_N_ITEMS;
      k_choose_q <= RST_K_CHOOSE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_N_ITEMS:  n_items_q  <= pwdata[CFG_W-1:0];
        REG_K_CHOOSE: k_choose_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_N_ITEMS:  prdata = {{(APB_DW-CFG_W){1'b0}}, n_items_q};
      REG_K_CHOOSE: prdata = {{(APB_DW-CFG_W){1'b0}}, k_choose_q};
      default:      prdata = '0;
    endcase
  end

  assign n_items_o  = n_items_q;
  assign k_choose_o = k_choose_q;
  assign cfg_wr_o   = wr_en;

endmodule
`default_nettype wire

// ===== design/kce_ctrl.sv =====
// Controller state machine sequencing load, bit scan and mask update.
`default_nettype none
module kce_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire kce_pkg::sts_t sts_i,
  output kce_pkg::cmd_t      cmd_o
);
  import kce_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.k_zero ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.bit_set || sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.bit_set && sts_i.is_last) state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && sts_i.bit_set && !sts_i.out_free |=> (state_q == ST_SCAN))
    else $error("scan left while result slot was busy");

  a_last_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && sts_i.bit_set && sts_i.is_last |=> (state_q == ST_UPDATE))
    else $error("last member not followed by mask update");

endmodule
`default_nettype wire

// ===== design/kce_dp.sv =====
// Datapath: selection mask, bit scanner, pivot tracking and result register.
`default_nettype none
module kce_dp #(
  parameter int unsigned MAX_N = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [kce_pkg::CFG_W-1:0] n_items_i,
  input  wire logic [kce_pkg::CFG_W-1:0] k_choose_i,
  input  wire logic                      cfg_wr_i,
  input  wire logic                      restart_i,
  input  wire kce_pkg::cmd_t             cmd_i,
  output kce_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [kce_pkg::IDX_W-1:0] element_index_o,
  output logic                           last_of_subset_o,
  output logic                           final_subset_o
);
  import kce_pkg::*;

  localparam int unsigned PW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned NW = $clog2(MAX_N + 1);

  logic [MAX_N-1:0] mask_q;
  logic [MAX_N-1:0] work_q;
  logic             started_q;
  logic             found_q;
  logic [PW-1:0]    pos_q;
  logic [NW-1:0]    cnt_q;
  logic [PW-1:0]    pivot_q;
  logic [NW-1:0]    above_q;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_last_q;
  logic             out_final_q;

  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    k_eff;
  logic [MAX_N-1:0] first_vec;
  logic [MAX_N-1:0] n_lim;
  logic [MAX_N-1:0] pair_lim;
  logic [MAX_N-1:0] m_sel;
  logic [MAX_N-1:0] work_shr;
  logic [MAX_N-1:0] next_mask;
  logic             reload;
  logic             found;
  logic             emit;
  logic [31:0]      run_top;

  always_comb begin
    if ({26'd0, n_items_i} > 32'(MAX_N)) n_eff = NW'(MAX_N);
    else                                  n_eff = NW'(n_items_i);
    if ({26'd0, k_choose_i} > 32'(n_eff)) k_eff = n_eff;
    else                                   k_eff = NW'(k_choose_i);
  end

  always_comb begin
    for (int j = 0; j < MAX_N; j++) begin
      first_vec[j] = (32'(j) < 32'(k_eff));
      n_lim[j]     = (32'(j) < 32'(n_eff));
      pair_lim[j]  = (32'(j) + 32'd1 < 32'(n_eff));
    end
  end

  assign reload   = restart_i || !started_q;
  assign m_sel    = (reload ? first_vec : mask_q) & n_lim;
  assign found    = |(m_sel & ~(m_sel >> 1) & pair_lim);
  assign work_shr = work_q >> 1;
  assign run_top  = 32'(pivot_q) + 32'(above_q) + 32'd1;

  always_comb begin
    for (int j = 0; j < MAX_N; j++) begin
      if (32'(j) < 32'(pivot_q)) next_mask[j] = work_q[j];
      else next_mask[j] = (32'(j) > 32'(pivot_q)) && (32'(j) <= run_top);
    end
  end

  assign sts_o.k_zero   = (k_eff == '0);
  assign sts_o.bit_set  = work_q[pos_q];
  assign sts_o.is_last  = (NW'(cnt_q + 1'b1) == k_eff);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign emit = cmd_i.step && work_q[pos_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= MAX_N'(1);
      started_q <= 1'b0;
    end else begin
      if (cmd_i.load && reload) begin
        mask_q    <= first_vec;
        started_q <= 1'b1;
      end
      if (cmd_i.update) mask_q <= found_q ? next_mask : first_vec;
      if (cfg_wr_i) started_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q  <= m_sel;
      found_q <= found;
      pos_q   <= '0;
      cnt_q   <= '0;
      pivot_q <= '0;
      above_q <= '0;
    end else if (cmd_i.step) begin
      pos_q <= pos_q + 1'b1;
      if (work_q[pos_q]) begin
        cnt_q <= cnt_q + 1'b1;
        if (pair_lim[pos_q] && !work_shr[pos_q]) begin
          pivot_q <= pos_q;
          above_q <= '0;
        end else begin
          above_q <= above_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (emit)        out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_idx_q   <= IDX_W'(32'(pos_q) + 32'd1);
      out_last_q  <= sts_o.is_last;
      out_final_q <= !found_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign element_index_o  = out_idx_q;
  assign last_of_subset_o = out_last_q;
  assign final_subset_o   = out_final_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending transaction");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && !cfg_wr_i |=> started_q)
    else $error("started flag not set after load");

endmodule
`default_nettype wire

// ===== design/k_combination_enumerator_unit.sv =====
// Top level of the lexicographic k-combination enumerator.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | restart_i
//  out     | output    | out_valid_o/out_ready_i| element_index_o, last_of_subset_o,
//          |           |                        | final_subset_o
//  apb     | input     | psel/penable/pready    | pwrite, paddr, pwdata, prdata
//
// One transaction has a load step, one scan step per mask position up to the
// highest member of the subset (at most N), and an update step; with k = 0 there is no scan.
// The scanner walks the selection mask one bit at a time.
// Reset clears the started flag; the first transaction loads the first subset.
// A busy result register stalls the scan; a new transaction is taken while the
// last result of the previous one still waits.
`default_nettype none
module k_combination_enumerator_unit #(
  parameter int unsigned MAX_N = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        restart_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [kce_pkg::IDX_W-1:0]   element_index_o,
  output logic                             last_of_subset_o,
  output logic                             final_subset_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kce_pkg::APB_AW-1:0]  paddr,
  input  wire logic [kce_pkg::APB_DW-1:0]  pwdata,
  output logic      [kce_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import kce_pkg::*;

  logic [CFG_W-1:0] n_items;
  logic [CFG_W-1:0] k_choose;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  kce_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .n_items_o  (n_items),
    .k_choose_o (k_choose),
    .cfg_wr_o   (cfg_wr)
  );

  kce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kce_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .n_items_i        (n_items),
    .k_choose_i       (k_choose),
    .cfg_wr_i         (cfg_wr),
    .restart_i        (restart_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .element_index_o  (element_index_o),
    .last_of_subset_o (last_of_subset_o),
    .final_subset_o   (final_subset_o)
  );

endmodule
`default_nettype wire

// ===== dv/kce_checker.sv =====
// Checker for the k-combination enumerator: mirrors the subset walk and compares every index.
`timescale 1ns / 1ps
module kce_checker #(
  parameter int unsigned MAX_N = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic                       restart_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [kce_pkg::IDX_W-1:0]  element_index_i,
  input  wire logic                       last_of_subset_i,
  input  wire logic                       final_subset_i,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [kce_pkg::APB_AW-1:0] paddr,
  input  wire logic [kce_pkg::APB_DW-1:0] pwdata,
  input  wire logic [kce_pkg::APB_DW-1:0] prdata,
  input  wire logic                       pready,
  output int                              errors_o,
  output int                              pending_o,
  output int                              checked_o
);
  import kce_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] element;
    logic             closes_subset;
    logic             last_subset;
  } member_t;

  member_t          member_q[$];
  member_t          seen;
  member_t          want;
  logic [CFG_W-1:0] n_items_q;
  logic [CFG_W-1:0] k_choose_q;
  logic [63:0]      sel_mask;
  bit               walking;
  int               errors;
  int               checked;

  function automatic logic [63:0] ones_below(input int unsigned cnt);
    if (cnt >= 64) return '1;
    return (64'd1 << cnt) - 64'd1;
  endfunction

  function automatic int unsigned set_size();
    int unsigned n;
    n = int'(n_items_q);
    if (n > MAX_N) n = MAX_N;
    return n;
  endfunction

  function automatic int unsigned subset_size();
    int unsigned k;
    k = int'(k_choose_q);
    if (k > set_size()) k = set_size();
    return k;
  endfunction

  task automatic flag(input string what, input int unsigned expected, input int unsigned actual);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expected, actual);
  endtask

  task automatic walk_subset(input logic restart);
    int unsigned n;
    int unsigned p;
    int unsigned pivot;
    int unsigned above;
    int          last_pos;
    bit          found;
    logic [63:0] m;
    member_t     mem;
    n        = set_size();
    pivot    = 0;
    above    = 0;
    last_pos = -1;
    found    = 1'b0;
    if (restart || !walking) begin
      sel_mask = ones_below(subset_size());
      walking  = 1'b1;
    end
    m = sel_mask & ones_below(n);
    for (p = 0; p + 1 < n; p++) begin
      if (m[p] && !m[p+1]) begin
        found = 1'b1;
        pivot = p;
      end
    end
    for (p = 0; p < n; p++) begin
      if (m[p]) begin
        mem.element       = IDX_W'(p + 1);
        mem.closes_subset = 1'b0;
        mem.last_subset   = !found;
        member_q.push_back(mem);
        last_pos = member_q.size() - 1;
      end
    end
    if (last_pos >= 0) member_q[last_pos].closes_subset = 1'b1;
    if (found) begin
      for (p = pivot + 1; p < n; p++) begin
        if (m[p]) above++;
      end
      sel_mask = (m & ones_below(pivot)) | (ones_below(above + 1) << (pivot + 1));
    end else begin
      sel_mask = ones_below(subset_size());
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_items_q  = RST_N_ITEMS;
      k_choose_q = RST_K_CHOOSE;
      sel_mask   = ones_below(subset_size());
      walking    = 1'b0;
      member_q.delete();
      errors     = 0;
      checked    = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[2]))
            REG_N_ITEMS: begin
              n_items_q = pwdata[CFG_W-1:0];
            end
            REG_K_CHOOSE: begin
              k_choose_q = pwdata[CFG_W-1:0];
            end
            default: ;
          endcase
          walking = 1'b0;
        end else if (reg_idx_e'(paddr[2]) == REG_K_CHOOSE) begin
          if (prdata !== APB_DW'(k_choose_q)) flag("k_choose readback", k_choose_q, prdata);
        end else begin
          if (prdata !== APB_DW'(n_items_q)) flag("n_items readback", n_items_q, prdata);
        end
      end
      if (in_valid_i && in_ready_i) walk_subset(restart_i);
      if (out_valid_i && out_ready_i) begin
        seen = '{element_index_i, last_of_subset_i, final_subset_i};
        if (member_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, got index %0d last %0b final %0b",
                   $time, element_index_i, last_of_subset_i, final_subset_i);
        end else begin
          want = member_q.pop_front();
          checked++;
          if (seen.element !== want.element)
            flag("element_index", want.element, seen.element);
          if (seen.closes_subset !== want.closes_subset)
            flag("last_of_subset", want.closes_subset, seen.closes_subset);
          if (seen.last_subset !== want.last_subset)
            flag("final_subset", want.last_subset, seen.last_subset);
        end
      end
    end
    errors_o  = errors;
    checked_o = checked;
    pending_o = member_q.size();
  end

endmodule

// ===== dv/k_combination_enumerator_unit_test.sv =====
// Testbench top for the k-combination enumerator: drives requests and registers, gives the verdict.
`timescale 1ns / 1ps
module k_combination_enumerator_unit_test;
  import kce_pkg::*;

  localparam int unsigned MAX_N         = 32;
  localparam int unsigned SETTLE_CYCLES = MAX_N + 8;
  localparam int          CYCLE_LIMIT   = 2_000_000;
  localparam int          REQUEST_GOAL  = 500;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              restart_i   = 1'b0;
  logic              out_ready_i = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [IDX_W-1:0]  element_index_o;
  logic              last_of_subset_o;
  logic              final_subset_o;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int                errors;
  int                pending;
  int                checked;
  int                cycles    = 0;
  int                requests  = 0;
  int                settings  = 0;
  int unsigned       idle_odds = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  k_combination_enumerator_unit #(
    .MAX_N(MAX_N)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .element_index_o (element_index_o),
    .last_of_subset_o(last_of_subset_o),
    .final_subset_o  (final_subset_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  kce_checker #(
    .MAX_N(MAX_N)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .restart_i       (restart_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .element_index_i (element_index_o),
    .last_of_subset_i(last_of_subset_o),
    .final_subset_i  (final_subset_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : sink
    int unsigned burst;
    forever begin
      burst = $urandom_range(1, 18);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        repeat (burst) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end else begin
        repeat (burst) begin
          @(negedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  task automatic send_request(input logic restart);
    int unsigned gap;
    gap = 0;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) gap = $urandom_range(1, 18);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    requests++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e idx, input logic write, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input int unsigned n, input int unsigned k);
    apb_access(REG_N_ITEMS, 1'b1, CFG_W'(n));
    apb_access(REG_K_CHOOSE, 1'b1, CFG_W'(k));
    apb_access(REG_N_ITEMS, 1'b0, '0);
    apb_access(REG_K_CHOOSE, 1'b0, '0);
    settings++;
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned k;
    int unsigned count;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    settle();
    configure(4, 2);
    repeat (7) send_request(1'b0);
    settle();
    configure(3, 3);
    send_request(1'b0);
    send_request(1'b1);
    settle();
    configure(0, 2);
    send_request(1'b0);
    send_request(1'b1);
    settle();
    configure(5, 0);
    send_request(1'b0);
    settle();
    configure(63, 40);
    send_request(1'b0);
    settle();
    configure(1, 9);
    send_request(1'b0);
    send_request(1'b0);
    settle();

    while (requests < REQUEST_GOAL) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 63);
        1: n = $urandom_range(9, 32);
        default: n = $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 7) == 0) k = $urandom_range(0, 63);
      else k = $urandom_range(1, (n == 0) ? 1 : ((n > 8) ? 8 : n));
      count = $urandom_range(10, 40);
      configure(n, k);
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 2;
        default: idle_odds = 5;
      endcase
      if (requests >= REQUEST_GOAL - 60) idle_odds = 0;
      repeat (count) send_request($urandom_range(0, 19) == 0);
      settle();
    end

    $display("Ran %0d requests over %0d register settings; %0d subset indices compared.",
             requests, settings, checked);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/kce_pkg.sv
design/kce_cfg.sv
design/kce_ctrl.sv
design/kce_dp.sv
design/k_combination_enumerator_unit.sv
dv/kce_checker.sv
dv/k_combination_enumerator_unit_test.sv
